// ----- rtl/ert_pkg.sv -----
// Shared types and codes for the exchange record table.
`default_nettype none
package ert_pkg;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BADLEN   = 3'd1,
        ST_FULL     = 3'd2,
        ST_DUP      = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        KIND_REQUEST      = 3'd0,
        KIND_RESPONSE     = 3'd1,
        KIND_NOTIFICATION = 3'd2,
        KIND_REGISTRATION = 3'd3,
        KIND_CANCELLATION = 3'd4
    } kind_t;

    localparam logic OP_READ   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // One stored exchange record.
    typedef struct packed {
        logic        valid;
        logic [63:0] token;
        logic [3:0]  tok_size;
        logic [63:0] path;
        logic [3:0]  path_len;
        logic        is_reg;
        logic [39:0] counter;
        logic [2:0]  counter_len;
        logic [63:0] keyid;
        logic [3:0]  keyid_len;
    } entry_t;

    // Match flags travelling down the chain of cells.
    typedef struct packed {
        logic tok_hit;
        logic path_hit;
        logic free;
    } match_t;

    // Command applied to the cells in the write cycle.
    typedef struct packed {
        logic write;
        logic clear;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } state_t;

    // Byte-length mask over 64 bits.
    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (len > 4'(b)) m[b*8 +: 8] = 8'hFF;
        end
        return m;
    endfunction

    function automatic logic key_eq(input logic [63:0] a, input logic [3:0] alen,
                                    input logic [63:0] b, input logic [3:0] blen);
        return (alen == blen) && (((a ^ b) & byte_mask(alen)) == 64'd0);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/ert_cell.sv -----
// One table entry: holds a record and compares it against the broadcast key.
`default_nettype none
module ert_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [63:0]       tok,
    input  wire logic [3:0]        tok_len,
    input  wire logic [63:0]       path,
    input  wire logic [3:0]        path_len,
    input  wire logic              is_reg,
    input  wire ert_pkg::entry_t   wr_entry,
    input  wire ert_pkg::cell_cmd_t cmd,
    output ert_pkg::match_t        match,
    output ert_pkg::entry_t        entry
);
    logic           valid_reg;
    ert_pkg::entry_t data_reg;

    // Valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.write) begin
            valid_reg <= 1'b1;
        end else if (cmd.clear) begin
            valid_reg <= 1'b0;
        end
    end

    // Record payload
    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            data_reg <= wr_entry;
        end
    end

    // Comparators
    always_comb begin
        match.tok_hit  = valid_reg &&
            ert_pkg::key_eq(data_reg.token, data_reg.tok_size, tok, tok_len);
        match.path_hit = valid_reg && (data_reg.is_reg == is_reg) &&
            ert_pkg::key_eq(data_reg.path, data_reg.path_len, path, path_len);
        match.free     = !valid_reg;
        entry          = data_reg;
        entry.valid    = valid_reg;
    end
endmodule
`default_nettype wire

// ----- rtl/ert_chain.sv -----
// Row of cells; priority flags ripple combinationally from cell 0 upward.
`default_nettype none
module ert_chain #(
    parameter int ENTRIES = 8
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic [63:0]     tok,
    input  wire logic [3:0]      tok_len,
    input  wire logic [63:0]     path,
    input  wire logic [3:0]      path_len,
    input  wire logic            is_reg,
    input  wire ert_pkg::entry_t wr_entry,
    input  wire logic            do_write,
    input  wire logic            do_clear,
    input  wire logic            use_path,
    output logic                 tok_any,
    output logic                 slot_any,
    output logic                 dup,
    output ert_pkg::entry_t      tok_entry
);
    ert_pkg::match_t   m      [ENTRIES];
    ert_pkg::entry_t   e      [ENTRIES];
    ert_pkg::cell_cmd_t c     [ENTRIES];
    logic [ENTRIES:0]  tok_seen, path_seen, free_seen;
    logic [ENTRIES-1:0] tok_first, slot_sel, path_first, free_first;
    ert_pkg::entry_t   acc    [ENTRIES+1];

    // Cells with first-hit chain
    assign tok_seen[0]  = 1'b0;
    assign path_seen[0] = 1'b0;
    assign free_seen[0] = 1'b0;
    assign acc[0]       = '0;

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        ert_cell u_cell (
            .aclk(aclk), .aresetn(aresetn),
            .tok(tok), .tok_len(tok_len), .path(path), .path_len(path_len),
            .is_reg(is_reg), .wr_entry(wr_entry), .cmd(c[i]),
            .match(m[i]), .entry(e[i])
        );
        assign tok_first[i]    = m[i].tok_hit && !tok_seen[i];
        assign path_first[i]   = m[i].path_hit && !path_seen[i];
        assign free_first[i]   = m[i].free && !free_seen[i];
        assign tok_seen[i+1]   = tok_seen[i] | m[i].tok_hit;
        assign path_seen[i+1]  = path_seen[i] | m[i].path_hit;
        assign free_seen[i+1]  = free_seen[i] | m[i].free;
        assign acc[i+1]        = tok_first[i] ? e[i] : acc[i];
        assign slot_sel[i]     = use_path ? (path_seen[ENTRIES] ? path_first[i]
                                                                : free_first[i])
                                          : tok_first[i];
        assign c[i].write      = do_write && slot_sel[i];
        assign c[i].clear      = do_clear && tok_first[i];
    end

    assign tok_any   = tok_seen[ENTRIES];
    assign slot_any  = path_seen[ENTRIES] | free_seen[ENTRIES];
    assign dup       = tok_any && ((tok_first & slot_sel) == '0);
    assign tok_entry = acc[ENTRIES];
endmodule
`default_nettype wire

// ----- rtl/exchange_record_table.sv -----
// Exchange record table: token lookup, insert and removal over a chain of cells.
//
// Input channel s_axis_*: one item per message. tdata carries opcode, msg_kind,
// token, path, counter and key id with their lengths. Output channel m_axis_*
// returns one item per input: status and, for a successful read, the stored
// counter and key id with their lengths (zero otherwise).
// An item is captured in the input register and evaluated against all cells
// once the output register is free; table writes happen on that evaluate edge
// and the result is loaded into the output register. No new item is taken
// until the held one is evaluated; the next item is taken while the result
// waits in the output register, so a stalled receiver holds at most one result
// plus one item. Output valid rises on the evaluate edge.
// Reset clears every valid bit and both channel states; record contents are
// left as they were and are never read while the entry is invalid.
`default_nettype none
module exchange_record_table #(
    parameter int ENTRIES     = 8,
    parameter int TOKEN_BYTES = 8,
    parameter int URI_BYTES   = 8,
    parameter int PIV_BYTES   = 5,
    parameter int KID_BYTES   = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // opcode, msg_kind[3], token_bytes[64], tok_size[4], path_bytes[64],
    // path_len[4], counter_bytes[40], counter_len[3], keyid_bytes[64], keyid_len[4]
    input  wire logic [255:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status[3], found_counter[40], found_counter_len[3], found_keyid[64],
    // found_keyid_len[4]
    output logic [119:0]      m_axis_tdata
);
    logic        in_full_reg;
    logic [250:0] in_reg;
    logic        out_valid_reg;
    logic [113:0] out_reg;

    logic        op;
    logic [2:0]  kind;
    logic [63:0] tok, path, kid;
    logic [3:0]  tok_len, path_len, kid_len;
    logic [39:0] ctr;
    logic [2:0]  ctr_len;

    assign op       = in_reg[0];
    assign kind     = in_reg[3:1];
    assign tok      = in_reg[67:4];
    assign tok_len  = in_reg[71:68];
    assign path     = in_reg[135:72];
    assign path_len = in_reg[139:136];
    assign ctr      = in_reg[179:140];
    assign ctr_len  = in_reg[182:180];
    assign kid      = in_reg[246:183];
    assign kid_len  = in_reg[250:247];

    logic exec;
    assign exec          = in_full_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_full_reg;

    // Decode
    logic is_reg, upd_ins, upd_rsp, rd_tok, tok_bad, any_bad;
    logic tok_any, slot_any, dup;
    ert_pkg::entry_t tok_entry, wr_entry;
    logic [2:0]  st;
    logic        do_write, do_clear;

    always_comb begin
        is_reg  = (kind == ert_pkg::KIND_REGISTRATION) ||
                  (kind == ert_pkg::KIND_CANCELLATION);
        upd_ins = (op == ert_pkg::OP_UPDATE) &&
                  (is_reg || kind == ert_pkg::KIND_REQUEST);
        upd_rsp = (op == ert_pkg::OP_UPDATE) && (kind == ert_pkg::KIND_RESPONSE);
        rd_tok  = (op == ert_pkg::OP_READ) && (kind == ert_pkg::KIND_RESPONSE ||
                                               kind == ert_pkg::KIND_NOTIFICATION);
        tok_bad = tok_len > 4'(TOKEN_BYTES);
        any_bad = tok_bad || path_len > 4'(URI_BYTES) ||
                  ctr_len > 3'(PIV_BYTES) || kid_len > 4'(KID_BYTES);
        st       = ert_pkg::ST_OK;
        do_write = 1'b0;
        do_clear = 1'b0;
        if (upd_ins) begin
            if (any_bad)       st = ert_pkg::ST_BADLEN;
            else if (!slot_any) st = ert_pkg::ST_FULL;
            else if (dup)      st = ert_pkg::ST_DUP;
            else               do_write = exec;
        end else if (upd_rsp || rd_tok) begin
            if (tok_bad)       st = ert_pkg::ST_BADLEN;
            else if (!tok_any) st = ert_pkg::ST_NOTFOUND;
            else               do_clear = exec && upd_rsp;
        end
        wr_entry             = '0;
        wr_entry.valid       = 1'b1;
        wr_entry.token       = tok & ert_pkg::byte_mask(tok_len);
        wr_entry.tok_size    = tok_len;
        wr_entry.path        = path & ert_pkg::byte_mask(path_len);
        wr_entry.path_len    = path_len;
        wr_entry.is_reg      = is_reg;
        wr_entry.counter     = ctr & 40'(ert_pkg::byte_mask({1'b0, ctr_len}));
        wr_entry.counter_len = ctr_len;
        wr_entry.keyid       = kid & ert_pkg::byte_mask(kid_len);
        wr_entry.keyid_len   = kid_len;
    end

    ert_chain #(.ENTRIES(ENTRIES)) u_chain (
        .aclk(aclk), .aresetn(aresetn),
        .tok(tok), .tok_len(tok_len), .path(path), .path_len(path_len),
        .is_reg(is_reg), .wr_entry(wr_entry),
        .do_write(do_write), .do_clear(do_clear), .use_path(upd_ins),
        .tok_any(tok_any), .slot_any(slot_any), .dup(dup), .tok_entry(tok_entry)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_full_reg <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            in_full_reg <= 1'b1;
        end else if (exec) begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_reg <= s_axis_tdata[250:0];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (exec) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            if (rd_tok && st == ert_pkg::ST_OK) begin
                out_reg <= {tok_entry.keyid_len, tok_entry.keyid,
                            tok_entry.counter_len, tok_entry.counter, st};
            end else begin
                out_reg <= {111'd0, st};
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_reg};
endmodule
`default_nettype wire

// ----- test/exchange_record_table_tb.sv -----
// Testbench for the exchange record table: directed and random message traffic checked per item.
`default_nettype none
module exchange_record_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SLOTS  = 8;
    localparam int MAX_TOK  = 8;
    localparam int MAX_PATH = 8;
    localparam int MAX_CTR  = 5;
    localparam int MAX_KID  = 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [3:0]  keyid_len;
        logic [63:0] keyid;
        logic [2:0]  counter_len;
        logic [39:0] counter;
        logic [3:0]  path_len;
        logic [63:0] path;
        logic [3:0]  tok_size;
        logic [63:0] token;
        logic [2:0]  kind;
        logic        op;
    } msg_t;

    typedef struct packed {
        logic [3:0]  keyid_len;
        logic [63:0] keyid;
        logic [2:0]  counter_len;
        logic [39:0] counter;
        logic [2:0]  status;
    } reply_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [255:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [119:0] m_axis_tdata;

    exchange_record_table u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Table mirror
    logic        tb_valid   [N_SLOTS];
    logic [63:0] tb_token   [N_SLOTS];
    logic [3:0]  tb_tok_len [N_SLOTS];
    logic [63:0] tb_path    [N_SLOTS];
    logic [3:0]  tb_path_len[N_SLOTS];
    logic        tb_is_reg  [N_SLOTS];
    logic [39:0] tb_ctr     [N_SLOTS];
    logic [2:0]  tb_ctr_len [N_SLOTS];
    logic [63:0] tb_kid     [N_SLOTS];
    logic [3:0]  tb_kid_len [N_SLOTS];

    reply_t expected_replies[$];
    int  errors = 0;
    int  cycles = 0;
    bit  src_idle_on = 1'b1;
    bit  sink_idle_on = 1'b1;
    bit  sink_hold = 1'b0;
    // tokens and paths recently used, to make hits likely
    logic [63:0] tok_pool[4];
    logic [63:0] path_pool[4];

    // Clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic logic [63:0] len_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) if (len > b) m[b*8 +: 8] = 8'hFF;
        return m;
    endfunction

    function automatic bit keys_match(input logic [63:0] a, input logic [3:0] al,
                                      input logic [63:0] b, input logic [3:0] bl);
        return (al == bl) && (((a ^ b) & len_mask(al)) == 64'd0);
    endfunction

    function automatic int token_slot(input logic [63:0] t, input logic [3:0] tl);
        for (int i = 0; i < N_SLOTS; i++)
            if (tb_valid[i] && keys_match(tb_token[i], tb_tok_len[i], t, tl)) return i;
        return N_SLOTS;
    endfunction

    // Apply one message to the mirror and return the reply it should give
    function automatic reply_t table_apply(input msg_t m);
        reply_t r;
        int slot, held;
        logic [2:0] k;
        bit reg_kind;
        r = '0;
        r.status = ert_pkg::ST_OK;
        k = m.kind;
        if (m.op == ert_pkg::OP_READ) begin
            if (k == ert_pkg::KIND_RESPONSE || k == ert_pkg::KIND_NOTIFICATION) begin
                if (m.tok_size > MAX_TOK) r.status = ert_pkg::ST_BADLEN;
                else begin
                    slot = token_slot(m.token, m.tok_size);
                    if (slot == N_SLOTS) r.status = ert_pkg::ST_NOTFOUND;
                    else begin
                        r.counter = tb_ctr[slot];
                        r.counter_len = tb_ctr_len[slot];
                        r.keyid = tb_kid[slot];
                        r.keyid_len = tb_kid_len[slot];
                    end
                end
            end
        end else begin
            if (k == ert_pkg::KIND_CANCELLATION) k = ert_pkg::KIND_REGISTRATION;
            if (k == ert_pkg::KIND_REQUEST || k == ert_pkg::KIND_REGISTRATION) begin
                reg_kind = (k == ert_pkg::KIND_REGISTRATION);
                if (m.tok_size > MAX_TOK || m.path_len > MAX_PATH ||
                    m.counter_len > MAX_CTR || m.keyid_len > MAX_KID) begin
                    r.status = ert_pkg::ST_BADLEN;
                end else begin
                    slot = N_SLOTS;
                    for (int i = 0; i < N_SLOTS; i++)
                        if (slot == N_SLOTS && tb_valid[i] && tb_is_reg[i] == reg_kind &&
                            keys_match(tb_path[i], tb_path_len[i], m.path, m.path_len))
                            slot = i;
                    for (int i = 0; i < N_SLOTS; i++)
                        if (slot == N_SLOTS && !tb_valid[i]) slot = i;
                    if (slot == N_SLOTS) r.status = ert_pkg::ST_FULL;
                    else begin
                        held = token_slot(m.token, m.tok_size);
                        if (held != N_SLOTS && held != slot) r.status = ert_pkg::ST_DUP;
                        else begin
                            tb_valid[slot]    = 1'b1;
                            tb_token[slot]    = m.token & len_mask(m.tok_size);
                            tb_tok_len[slot]  = m.tok_size;
                            tb_path[slot]     = m.path & len_mask(m.path_len);
                            tb_path_len[slot] = m.path_len;
                            tb_is_reg[slot]   = reg_kind;
                            tb_ctr[slot]      = m.counter &
                                                40'(len_mask({1'b0, m.counter_len}));
                            tb_ctr_len[slot]  = m.counter_len;
                            tb_kid[slot]      = m.keyid & len_mask(m.keyid_len);
                            tb_kid_len[slot]  = m.keyid_len;
                        end
                    end
                end
            end else if (k == ert_pkg::KIND_RESPONSE) begin
                if (m.tok_size > MAX_TOK) r.status = ert_pkg::ST_BADLEN;
                else begin
                    slot = token_slot(m.token, m.tok_size);
                    if (slot == N_SLOTS) r.status = ert_pkg::ST_NOTFOUND;
                    else tb_valid[slot] = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // Send one item, with random idle cycles before it; valid stays up after
    // the accept so back-to-back items need only one drive per edge
    task automatic send_msg(input msg_t m);
        while (src_idle_on && $urandom_range(99) < 30) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tdata  <= {5'd0, m};
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        expected_replies.push_back(table_apply(m));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic msg_t make_msg(input logic op, input logic [2:0] kind,
                                      input logic [63:0] tok, input logic [3:0] tl,
                                      input logic [63:0] path, input logic [3:0] pl);
        msg_t m;
        m.op = op; m.kind = kind; m.token = tok; m.tok_size = tl;
        m.path = path; m.path_len = pl;
        m.counter = 40'({$urandom, $urandom}); m.counter_len = 3'($urandom_range(MAX_CTR));
        m.keyid = {$urandom, $urandom}; m.keyid_len = 4'($urandom_range(MAX_KID));
        return m;
    endfunction

    function automatic msg_t rand_msg();
        msg_t m;
        int sel;
        sel = $urandom_range(99);
        m = make_msg(1'($urandom_range(1)), 3'($urandom_range(4)),
                     tok_pool[$urandom_range(3)], 4'($urandom_range(MAX_TOK)),
                     path_pool[$urandom_range(3)], 4'($urandom_range(2)));
        if (m.op == ert_pkg::OP_READ && $urandom_range(3) != 0)
            m.kind = ($urandom_range(1) != 0) ? ert_pkg::KIND_RESPONSE
                                              : ert_pkg::KIND_NOTIFICATION;
        if (sel < 8) begin
            // noise: anything the fields allow
            m.kind = 3'($urandom); m.token = {$urandom, $urandom};
            m.tok_size = 4'($urandom); m.path = {$urandom, $urandom};
            m.path_len = 4'($urandom); m.counter_len = 3'($urandom);
            m.keyid_len = 4'($urandom);
        end else if (sel < 14) begin
            m.path_len = 4'($urandom_range(MAX_PATH));
        end
        return m;
    endfunction

    // Extremes, every kind and each corner case
    task automatic test_directed();
        msg_t m;
        m = make_msg(ert_pkg::OP_READ, ert_pkg::KIND_RESPONSE, 64'h1, 4'd1, 64'h0, 4'd0);
        send_msg(m);                                   // read on empty table
        m = make_msg(ert_pkg::OP_UPDATE, ert_pkg::KIND_REQUEST, '1, 4'd8, '1, 4'd8);
        m.counter = '1; m.counter_len = 3'd5; m.keyid = '1; m.keyid_len = 4'd8;
        send_msg(m);
        m.op = ert_pkg::OP_READ; m.kind = ert_pkg::KIND_NOTIFICATION; send_msg(m);
        m.op = ert_pkg::OP_READ; m.kind = ert_pkg::KIND_RESPONSE; m.tok_size = 4'd15;
        send_msg(m);
        m = make_msg(ert_pkg::OP_UPDATE, ert_pkg::KIND_REQUEST, 64'h5, 4'd1, 64'h7, 4'd9);
        send_msg(m);
        m.path_len = 4'd1; m.counter_len = 3'd7; send_msg(m);
        m.counter_len = 3'd0; m.keyid_len = 4'd15; send_msg(m);
        m.keyid_len = 4'd0; m.tok_size = 4'd0; send_msg(m);   // empty token
        m = make_msg(ert_pkg::OP_UPDATE, ert_pkg::KIND_REGISTRATION, '1, 4'd8, 64'h7, 4'd1);
        send_msg(m);                                   // token held elsewhere
        m = make_msg(ert_pkg::OP_UPDATE, ert_pkg::KIND_CANCELLATION, 64'h33, 4'd1,
                     64'h7, 4'd1);
        send_msg(m);
        m = make_msg(ert_pkg::OP_UPDATE, ert_pkg::KIND_NOTIFICATION, 64'h33, 4'd1,
                     64'h0, 4'd0);
        send_msg(m);
        m = make_msg(ert_pkg::OP_READ, ert_pkg::KIND_REQUEST, 64'h33, 4'd1, 64'h0, 4'd0);
        send_msg(m);
        for (int k = 5; k < 8; k++) begin
            m = make_msg(k[0], 3'(k), 64'h33, 4'd1, 64'h0, 4'd0); send_msg(m);
        end
        // fill the table until inserts overflow it
        for (int i = 0; i < 8; i++) begin
            m = make_msg(ert_pkg::OP_UPDATE, ert_pkg::KIND_REQUEST, 64'h100 + i, 4'd2,
                         64'h40 + i, 4'd1);
            send_msg(m);
        end
        m = make_msg(ert_pkg::OP_UPDATE, ert_pkg::KIND_RESPONSE, 64'h99, 4'd2, 64'h0, 4'd0);
        send_msg(m);
        m = make_msg(ert_pkg::OP_UPDATE, ert_pkg::KIND_RESPONSE, 64'h33, 4'd1, 64'h0, 4'd0);
        send_msg(m);
        m = make_msg(ert_pkg::OP_UPDATE, ert_pkg::KIND_RESPONSE, 64'h33, 4'd9, 64'h0, 4'd0);
        send_msg(m);
        wait_drained();
    endtask

    // Random traffic; one stretch without idling
    task automatic test_random(input int count);
        msg_t m;
        for (int n = 0; n < count; n++) begin
            if (n == count / 3) begin src_idle_on = 1'b0; sink_idle_on = 1'b0; end
            if (n == count / 2) begin src_idle_on = 1'b1; sink_idle_on = 1'b1; end
            if (n % 40 == 0) tok_pool[$urandom_range(3)] = {$urandom, $urandom};
            if (n % 60 == 0) path_pool[$urandom_range(3)] = {$urandom, $urandom};
            m = rand_msg();
            send_msg(m);
        end
    endtask

    // Receiver holds off while items keep coming
    task automatic test_backpressure();
        sink_hold = 1'b1;
        fork
            begin
                repeat (200) @(posedge aclk);
                sink_hold = 1'b0;
            end
            test_random(20);
        join
        wait_drained();
    endtask

    // Result channel ready
    always @(posedge aclk) begin
        m_axis_tready <= !sink_hold && !(sink_idle_on && $urandom_range(99) < 30);
    end

    // Result checker
    always @(posedge aclk) begin
        reply_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[113:0];
            if (expected_replies.size() == 0) begin
                $error("unexpected result item %h", m_axis_tdata);
                errors++;
            end else begin
                want = expected_replies.pop_front();
                if (got.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status); errors++;
                end
                if (got.counter !== want.counter) begin
                    $error("found_counter exp %h got %h", want.counter, got.counter); errors++;
                end
                if (got.counter_len !== want.counter_len) begin
                    $error("found_counter_len exp %0d got %0d", want.counter_len,
                           got.counter_len); errors++;
                end
                if (got.keyid !== want.keyid) begin
                    $error("found_keyid exp %h got %h", want.keyid, got.keyid); errors++;
                end
                if (got.keyid_len !== want.keyid_len) begin
                    $error("found_keyid_len exp %0d got %0d", want.keyid_len,
                           got.keyid_len); errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < N_SLOTS; i++) tb_valid[i] = 1'b0;
        for (int i = 0; i < 4; i++) begin
            tok_pool[i] = {$urandom, $urandom};
            path_pool[i] = {$urandom, $urandom};
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(400);
        test_backpressure();
        test_random(400);
        wait_drained();
        repeat (10) @(posedge aclk);
        if (errors == 0 && expected_replies.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
